// File: rtl/cfp_pkg.sv
package cfp_pkg;

   // Parser position within a frame.
   typedef enum logic [3:0] {
      PH_HEAD1 = 4'd0,
      PH_HEAD2 = 4'd1,
      PH_CMD   = 4'd2,
      PH_LEN   = 4'd3,
      PH_PAY   = 4'd4,
      PH_CRCH  = 4'd5,
      PH_CRCL  = 4'd6,
      PH_TAIL1 = 4'd7,
      PH_TAIL2 = 4'd8
   } phase_type;

   // Sequencer: taking bytes, reading the payload store, loading a result.
   typedef enum logic [1:0] {
      CTL_IDLE = 2'd0,
      CTL_READ = 2'd1,
      CTL_LOAD = 2'd2
   } ctl_type;

   // Command from the sequencer to the CRC unit.
   typedef struct packed {
      logic       start;
      logic       seed_init;
      logic [7:0] data;
   } crc_cmd_type;

   localparam logic [2:0] CSR_HEAD_FIRST    = 3'd0;
   localparam logic [2:0] CSR_HEAD_SECOND   = 3'd1;
   localparam logic [2:0] CSR_TAIL_FIRST    = 3'd2;
   localparam logic [2:0] CSR_TAIL_SECOND   = 3'd3;
   localparam logic [2:0] CSR_PAYLOAD_LIMIT = 3'd4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

endpackage

// File: rtl/cfp_if.sv
interface cfp_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_result_if;
   logic       valid;
   logic       ready;
   logic [7:0] command;
   logic [6:0] frame_length;
   logic [5:0] byte_index;
   logic [7:0] payload_byte;
   logic       has_payload;
   logic       last;

   modport source (output valid, output command, output frame_length, output byte_index,
                   output payload_byte, output has_payload, output last, input ready);
   modport sink   (input valid, input command, input frame_length, input byte_index,
                   input payload_byte, input has_payload, input last, output ready);
endinterface

// File: rtl/cfp_crc_unit.sv
module cfp_crc_unit
   import cfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_cmd_type cmd,
   output logic        busy,
   output logic [15:0] crc
);

   logic [15:0] crc_ff, crc_in;
   logic        busy_ff, busy_in;
   logic [15:0] base;

   // Four bits of the MSB-first CRC shift per call.
   function automatic logic [15:0] step4(input logic [15:0] c_init);
      logic [15:0] c;
      c = c_init;
      for (int k = 0; k < 4; k++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else       c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // A byte is folded in as two halves: the first half on the start cycle,
   // the second half on the next one.
   always_comb begin
      base    = cmd.seed_init ? CRC_INIT : crc_ff;
      crc_in  = crc_ff;
      busy_in = 1'b0;
      if (cmd.start) begin
         crc_in  = step4(base ^ {cmd.data, 8'h00});
         busy_in = 1'b1;
      end else if (busy_ff) begin
         crc_in  = step4(crc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
   assign crc  = crc_ff;

endmodule

// File: rtl/cfp_payload_mem.sv
module cfp_payload_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/crc_framed_packet_parser_top.sv
// Byte-serial framed packet receiver. Each transfer on req carries one received
// byte; frames are head, head, command, length, payload, CRC high, CRC low,
// tail, tail, with a CRC-16 CCITT-FALSE over head through payload. A byte that
// feeds the CRC holds off the next byte while the CRC unit, which folds in four
// bits per cycle, works on its second half. After the second tail byte of a good
// frame the block streams one rsp transfer per payload byte (or one empty
// result for a zero-length frame), each made by a registered read of the
// payload store followed by a load of the output register, and takes no bytes
// until the last result is loaded. A result waiting in the output register
// does not hold off new bytes. The frame heads, tails and length limit are
// written over the csr port by the user only while idle; the block does not enforce it.
module crc_framed_packet_parser_top
   import cfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic         clock,
   input  logic         reset,
   cfp_byte_if.sink     req,
   cfp_result_if.source rsp,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int         AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   phase_type   phase_ff, phase_in;
   ctl_type     ctl_ff, ctl_in;
   logic [7:0]  head1_ff, head1_in, head2_ff, head2_in;
   logic [7:0]  tail1_ff, tail1_in, tail2_ff, tail2_in;
   logic [6:0]  limit_ff, limit_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [6:0]  len_ff, len_in;
   logic [6:0]  rem_ff, rem_in;
   logic [6:0]  wpos_ff, wpos_in;
   logic [6:0]  rd_ff, rd_in;
   logic [15:0] rcrc_ff, rcrc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_cmd_ff, rsp_cmd_in;
   logic [6:0]  rsp_len_ff, rsp_len_in;
   logic [5:0]  rsp_idx_ff, rsp_idx_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_has_ff, rsp_has_in;
   logic        rsp_last_ff, rsp_last_in;

   crc_cmd_type crc_cmd;
   logic        crc_busy;
   logic [15:0] crc_value;

   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_rdata;

   logic       accept;
   logic [7:0] rx;
   logic [7:0] limit_eff;
   logic       last_now;

   cfp_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .cmd   (crc_cmd),
      .busy  (crc_busy),
      .crc   (crc_value)
   );

   cfp_payload_mem #(
      .DEPTH (MAX_PAYLOAD),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (rx),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req.ready = (ctl_ff == CTL_IDLE) && !crc_busy;
   assign accept    = req.valid && req.ready;
   assign rx        = req.rx_byte;

   assign limit_eff = ({1'b0, limit_ff} > MAX_LEN) ? MAX_LEN : {1'b0, limit_ff};
   assign last_now  = (len_ff == 7'd0) || (rd_ff == (len_ff - 7'd1));

   always_comb begin
      phase_in     = phase_ff;
      ctl_in       = ctl_ff;
      head1_in     = head1_ff;
      head2_in     = head2_ff;
      tail1_in     = tail1_ff;
      tail2_in     = tail2_ff;
      limit_in     = limit_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      wpos_in      = wpos_ff;
      rd_in        = rd_ff;
      rcrc_in      = rcrc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      crc_cmd      = '0;
      crc_cmd.data = rx;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = AW'(wpos_ff);
      mem_raddr    = AW'(rd_ff);

      if (csr_we) begin
         unique case (csr_index)
            CSR_HEAD_FIRST:    head1_in = csr_wdata;
            CSR_HEAD_SECOND:   head2_in = csr_wdata;
            CSR_TAIL_FIRST:    tail1_in = csr_wdata;
            CSR_TAIL_SECOND:   tail2_in = csr_wdata;
            CSR_PAYLOAD_LIMIT: limit_in = csr_wdata[6:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HEAD1: begin
               if (rx == head1_ff) begin
                  crc_cmd.start     = 1'b1;
                  crc_cmd.seed_init = 1'b1;
                  phase_in          = PH_HEAD2;
               end
            end
            PH_HEAD2: begin
               if (rx == head2_ff) begin
                  crc_cmd.start = 1'b1;
                  phase_in      = PH_CMD;
               end else begin
                  phase_in = PH_HEAD1;
               end
            end
            PH_CMD: begin
               cmd_in        = rx;
               crc_cmd.start = 1'b1;
               phase_in      = PH_LEN;
            end
            PH_LEN: begin
               if (rx > limit_eff) begin
                  phase_in = PH_HEAD1;
               end else begin
                  crc_cmd.start = 1'b1;
                  len_in        = rx[6:0];
                  rem_in        = rx[6:0];
                  wpos_in       = 7'd0;
                  phase_in      = (rx != 8'd0) ? PH_PAY : PH_CRCH;
               end
            end
            PH_PAY: begin
               mem_we        = 1'b1;
               wpos_in       = wpos_ff + 7'd1;
               crc_cmd.start = 1'b1;
               rem_in        = rem_ff - 7'd1;
               if (rem_ff == 7'd1) phase_in = PH_CRCH;
            end
            PH_CRCH: begin
               rcrc_in  = {rx, 8'h00};
               phase_in = PH_CRCL;
            end
            PH_CRCL: begin
               rcrc_in  = {rcrc_ff[15:8], rx};
               phase_in = PH_TAIL1;
            end
            PH_TAIL1: begin
               phase_in = (rx == tail1_ff) ? PH_TAIL2 : PH_HEAD1;
            end
            PH_TAIL2: begin
               phase_in = PH_HEAD1;
               if ((rx == tail2_ff) && (crc_value == rcrc_ff)) begin
                  rd_in  = 7'd0;
                  ctl_in = (len_ff == 7'd0) ? CTL_LOAD : CTL_READ;
               end
            end
            default: phase_in = PH_HEAD1;
         endcase
      end

      unique case (ctl_ff)
         CTL_IDLE: ;
         CTL_READ: begin
            mem_re = 1'b1;
            ctl_in = CTL_LOAD;
         end
         CTL_LOAD: begin
            // The read data holds until the output register frees up.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cmd_in   = cmd_ff;
               rsp_len_in   = len_ff;
               rsp_idx_in   = rd_ff[5:0];
               rsp_has_in   = (len_ff != 7'd0);
               rsp_byte_in  = (len_ff != 7'd0) ? mem_rdata : 8'd0;
               rsp_last_in  = last_now;
               if (last_now) begin
                  ctl_in = CTL_IDLE;
               end else begin
                  rd_in  = rd_ff + 7'd1;
                  ctl_in = CTL_READ;
               end
            end
         end
         default: ctl_in = CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD1;
         ctl_ff       <= CTL_IDLE;
         head1_ff     <= 8'hAA;
         head2_ff     <= 8'h55;
         tail1_ff     <= 8'h55;
         tail2_ff     <= 8'hAA;
         limit_ff     <= 7'd64;
         cmd_ff       <= 8'd0;
         len_ff       <= 7'd0;
         rem_ff       <= 7'd0;
         wpos_ff      <= 7'd0;
         rd_ff        <= 7'd0;
         rcrc_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ctl_ff       <= ctl_in;
         head1_ff     <= head1_in;
         head2_ff     <= head2_in;
         tail1_ff     <= tail1_in;
         tail2_ff     <= tail2_in;
         limit_ff     <= limit_in;
         cmd_ff       <= cmd_in;
         len_ff       <= len_in;
         rem_ff       <= rem_in;
         wpos_ff      <= wpos_in;
         rd_ff        <= rd_in;
         rcrc_ff      <= rcrc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.command      = rsp_cmd_ff;
   assign rsp.frame_length = rsp_len_ff;
   assign rsp.byte_index   = rsp_idx_ff;
   assign rsp.payload_byte = rsp_byte_ff;
   assign rsp.has_payload  = rsp_has_ff;
   assign rsp.last         = rsp_last_ff;

endmodule
